// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the motor speed PID unit
// Field widths, register indexes, limits and the structs passed between the
// configuration block, the PID core and the top level.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Loop geometry
  localparam int MOTORS    = 4;
  localparam int MIDX_W    = 2;   // index into per-motor state
  localparam int SLOTS     = 4;   // command slots in the frame
  localparam int FRAC_BITS = 8;

  // Field widths
  localparam int MOTOR_W   = 3;
  localparam int SPEED_W   = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INT_W     = 22;
  localparam int GAIN_W    = 24;
  localparam int DZ_W      = 16;
  localparam int ISTART_W  = 17;
  localparam int IMAX_W    = 20;
  localparam int CUR_W     = 15;
  localparam int SLOT_W    = 16;
  localparam int FRAME_W   = 64;
  localparam int SUM_W     = 48;

  // Current limit
  localparam int CUR_LIMIT = 10000;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DZ     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ISTART = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAX   = 3'd5;

  localparam logic signed [GAIN_W-1:0] KP_RESET = 24'sd5120;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [DZ_W-1:0]          dead_zone;
    logic [ISTART_W-1:0]      integral_start;
    logic [IMAX_W-1:0]        integral_max;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;
    logic [MOTOR_W-1:0]        motor_number;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      frame_payload;
    logic                    current_clipped;
    logic signed [CUR_W-1:0] drive_current;
    logic [MOTOR_W-1:0]      motor_slot;
  } result_t;

endpackage

// ===== sv/msp_cfg.sv =====
// ----------------------------------------------------------------------------
// msp_cfg: configuration registers
// Holds gains, dead zone and integral limits; written through a plain write
// port, unknown indexes are ignored.
// ----------------------------------------------------------------------------
module msp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0] cfg_data,
  output msp_pkg::cfg_t                  cfg
);
  import msp_pkg::*;

  // Decode the index and load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= KP_RESET;
      cfg.ki             <= '0;
      cfg.kd             <= '0;
      cfg.dead_zone      <= '0;
      cfg.integral_start <= '0;
      cfg.integral_max   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:     cfg.kp             <= signed'(cfg_data[GAIN_W-1:0]);
        REG_KI:     cfg.ki             <= signed'(cfg_data[GAIN_W-1:0]);
        REG_KD:     cfg.kd             <= signed'(cfg_data[GAIN_W-1:0]);
        REG_DZ:     cfg.dead_zone      <= cfg_data[DZ_W-1:0];
        REG_ISTART: cfg.integral_start <= cfg_data[ISTART_W-1:0];
        REG_IMAX:   cfg.integral_max   <= cfg_data[IMAX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/msp_core.sv =====
// ----------------------------------------------------------------------------
// msp_core: per-motor PID state and single-pass PID evaluation
// Reads the motor's integral, last error and command slot, computes the
// saturated current and frame, and commits the new state when told to.
// ----------------------------------------------------------------------------
module msp_core (
  input  logic                clk,
  input  logic                rst,
  input  msp_pkg::cfg_t       cfg,
  input  msp_pkg::in_item_t   item,
  input  logic                commit,
  output msp_pkg::result_t    result
);
  import msp_pkg::*;

  logic signed [INT_W-1:0]  integral_sum   [MOTORS];
  logic signed [ERR_W-1:0]  previous_error [MOTORS];
  logic [SLOT_W-1:0]        command_slots  [MOTORS];

  logic                     motor_ok;
  logic [MIDX_W-1:0]        idx;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         err_mag;
  logic                     in_dead;
  logic signed [ERR_W-1:0]  err_z;
  logic [ERR_W-1:0]         mag_z;
  logic signed [INT_W-1:0]  int_old;
  logic signed [ERR_W-1:0]  last;
  logic signed [INT_W-1:0]  int_add;
  logic signed [INT_W-1:0]  imax;
  logic signed [INT_W-1:0]  int_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [GAIN_W+ERR_W-1:0]  p_kp;
  logic signed [GAIN_W+INT_W-1:0]  p_ki;
  logic signed [GAIN_W+DIFF_W-1:0] p_kd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [SUM_W-1:0]  raw;
  logic signed [SLOT_W-1:0] cur;
  logic                     clip;
  logic [SLOT_W-1:0]        slot_view [SLOTS];

  // Motor select
  assign motor_ok = (item.motor_number >= MOTOR_W'(1)) &&
                    (item.motor_number <= MOTOR_W'(MOTORS));
  assign idx      = MIDX_W'(item.motor_number - MOTOR_W'(1));

  // Error and dead zone
  assign err     = ERR_W'(item.target_speed) - ERR_W'(item.measured_speed);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign in_dead = err_mag < ERR_W'(cfg.dead_zone);
  assign err_z   = in_dead ? '0 : err;
  assign mag_z   = in_dead ? '0 : err_mag;
  assign int_old = in_dead ? '0 : integral_sum[idx];
  assign last    = in_dead ? '0 : previous_error[idx];

  // Separated integration with clamp
  assign int_add = int_old + INT_W'(err_z);
  assign imax    = signed'(INT_W'(cfg.integral_max));
  always_comb begin
    int_next = int_old;
    if (mag_z < cfg.integral_start) begin
      if (int_add > imax) begin
        int_next = imax;
      end else if (int_add < -imax) begin
        int_next = -imax;
      end else begin
        int_next = int_add;
      end
    end
  end

  // PID products and sum
  assign diff = DIFF_W'(err_z) - DIFF_W'(last);
  assign p_kp = cfg.kp * err_z;
  assign p_ki = cfg.ki * int_next;
  assign p_kd = cfg.kd * diff;
  assign sum  = SUM_W'(p_kp) + SUM_W'(p_ki) + SUM_W'(p_kd);

  // Scale down, truncating toward zero
  assign sum_adj = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
  assign raw     = sum_adj >>> FRAC_BITS;

  // Saturate to the current limit
  always_comb begin
    clip = 1'b0;
    cur  = SLOT_W'(raw);
    if (raw > SUM_W'(CUR_LIMIT)) begin
      cur  = SLOT_W'(CUR_LIMIT);
      clip = 1'b1;
    end else if (raw < -SUM_W'(CUR_LIMIT)) begin
      cur  = SLOT_W'(-CUR_LIMIT);
      clip = 1'b1;
    end
  end

  // Frame with this motor's slot replaced; slot 1 sits in the top bits
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_view[k] = '0;
      if (k < MOTORS) begin
        slot_view[k] = command_slots[k];
        if (motor_ok && (idx == MIDX_W'(k))) begin
          slot_view[k] = cur;
        end
      end
    end
  end

  always_comb begin
    result.motor_slot      = item.motor_number;
    result.drive_current   = motor_ok ? CUR_W'(cur) : '0;
    result.current_clipped = motor_ok && clip;
    for (int k = 0; k < SLOTS; k++) begin
      result.frame_payload[SLOT_W*(SLOTS-1-k) +: SLOT_W] = slot_view[k];
    end
  end

  // Commit per-motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MOTORS; m++) begin
        integral_sum[m]   <= '0;
        previous_error[m] <= '0;
        command_slots[m]  <= '0;
      end
    end else if (commit && motor_ok) begin
      integral_sum[idx]   <= int_next;
      previous_error[idx] <= err_z;
      command_slots[idx]  <= cur;
    end
  end

endmodule

// ===== sv/motor_speed_pid_current_cmd_unit.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pid_current_cmd_unit: per-motor PID speed loop
// Path: the input transaction goes into the input register, then through one
// pass of the PID core into the result register.
// Throughput: one transaction per cycle unless the result stream stalls;
// per-motor state is updated in the same cycle the result is registered,
// so back-to-back items see it.
// Reset: synchronous, clears gains to defaults and all per-motor state.
// ----------------------------------------------------------------------------
module motor_speed_pid_current_cmd_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] motor_number, [18:3] measured_speed, [34:19] target_speed, zero pad
  input  logic [msp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] motor_slot, [17:3] drive_current, [81:18] frame_payload, zero pad
  output logic [msp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] current_clipped
  output logic [0:0]                      m_axis_tuser
);
  import msp_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid;
  result_t  core_result;
  result_t  out_result;
  logic     out_valid;
  logic     out_free;
  logic     fire;

  msp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the core pass fires when the result register can load
  assign out_free      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
  end

  msp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (in_item),
    .commit (fire),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (OUT_TDATA_W - FRAME_W - CUR_W - MOTOR_W)'(0),
    out_result.frame_payload,
    out_result.drive_current,
    out_result.motor_slot
  };
  assign m_axis_tuser  = out_result.current_clipped;

  // Current stays within the limit
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.drive_current <= CUR_W'(CUR_LIMIT) &&
                   out_result.drive_current >= -CUR_W'(CUR_LIMIT)))
    else $error("drive current beyond limit");

  // A clipped result sits exactly on the limit
  a_clip_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.current_clipped) |->
      (out_result.drive_current == CUR_W'(CUR_LIMIT) ||
       out_result.drive_current == -CUR_W'(CUR_LIMIT)))
    else $error("clipped result not at limit");

  // Unknown motor numbers give a zero, unclipped command
  a_bad_motor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.motor_slot == MOTOR_W'(0) ||
                   out_result.motor_slot > MOTOR_W'(MOTORS))) |->
      (out_result.drive_current == '0 && !out_result.current_clipped))
    else $error("invalid motor produced a command");

  // Nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

// ===== sim/motor_speed_pid_current_cmd_unit_test.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pid_current_cmd_unit_test: self-checking bench for the PID unit
// Drives speed feedback transactions into the per-motor PID loop and predicts
// each current command and command frame with a scoreboard that keeps its own
// copy of the gains and the per-motor integral and error history. A directed
// pass covers field extremes, invalid motor numbers, dead zone and integral
// separation and clamp. Random passes follow under several gain settings,
// with random idling on both streams, a long result back-pressure and a full
// drain mid-run.
// ----------------------------------------------------------------------------
module motor_speed_pid_current_cmd_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 228;
  localparam int MAX_PRINTS   = 40;

  typedef enum {GAINS_SMALL, GAINS_WIDE, GAINS_MAX, GAINS_MIN, GAINS_OFF} gain_plan_t;

  // Predicts current commands and checks them in order of arrival
  class current_cmd_scoreboard_t;
    cfg_t              gains;
    longint            integral_acc [MOTORS];
    longint            last_error [MOTORS];
    logic [SLOT_W-1:0] slot_cmd [SLOTS];
    result_t           expected_cmds [$];
    int                errors;

    function new();
      gains    = '0;
      gains.kp = KP_RESET;
      foreach (integral_acc[k]) integral_acc[k] = 0;
      foreach (last_error[k]) last_error[k] = 0;
      foreach (slot_cmd[k]) slot_cmd[k] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP:     gains.kp = data;
        REG_KI:     gains.ki = data;
        REG_KD:     gains.kd = data;
        REG_DZ:     gains.dead_zone = data[DZ_W-1:0];
        REG_ISTART: gains.integral_start = data[ISTART_W-1:0];
        REG_IMAX:   gains.integral_max = data[IMAX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    // Run one feedback transaction through the loop and queue its command
    function void note_feedback(in_item_t fb);
      result_t want;
      longint  err, dz, istart, imax, sum, raw, cur;
      int      m;
      want = '0;
      want.motor_slot = fb.motor_number;
      if (fb.motor_number >= 1 && fb.motor_number <= MOTORS) begin
        m      = fb.motor_number - 1;
        dz     = gains.dead_zone;
        istart = gains.integral_start;
        imax   = gains.integral_max;
        err    = longint'($signed(fb.target_speed)) - longint'($signed(fb.measured_speed));
        // dead zone clears the error and the motor's history
        if (err > -dz && err < dz) begin
          err = 0;
          integral_acc[m] = 0;
          last_error[m] = 0;
        end
        // integrate small errors only, then clamp
        if (err > -istart && err < istart) begin
          integral_acc[m] += err;
          if (integral_acc[m] > imax)
            integral_acc[m] = imax;
          else if (integral_acc[m] < -imax)
            integral_acc[m] = -imax;
        end
        sum = longint'($signed(gains.kp)) * err
            + longint'($signed(gains.ki)) * integral_acc[m]
            + longint'($signed(gains.kd)) * (err - last_error[m]);
        raw = sum / (longint'(1) << FRAC_BITS);
        last_error[m] = err;
        // saturate to the current limit
        cur = raw;
        if (raw > CUR_LIMIT) begin
          cur = CUR_LIMIT;
          want.current_clipped = 1'b1;
        end else if (raw < -CUR_LIMIT) begin
          cur = -CUR_LIMIT;
          want.current_clipped = 1'b1;
        end
        slot_cmd[m] = cur[SLOT_W-1:0];
        want.drive_current = cur[CUR_W-1:0];
      end
      for (int k = 0; k < SLOTS; k++)
        want.frame_payload[SLOT_W*(SLOTS-1-k) +: SLOT_W] = slot_cmd[k];
      expected_cmds.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Compare one result transaction with the oldest prediction
    task check_command(result_t got);
      result_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result for motor %0d with nothing pending", got.motor_slot));
      end else begin
        want = expected_cmds.pop_front();
        if (got.motor_slot !== want.motor_slot)
          report($sformatf("motor_slot %0d, predicted %0d", got.motor_slot,
                           want.motor_slot));
        if (got.drive_current !== want.drive_current)
          report($sformatf("motor %0d drive_current %0d, predicted %0d", want.motor_slot,
                           got.drive_current, want.drive_current));
        if (got.current_clipped !== want.current_clipped)
          report($sformatf("motor %0d current_clipped %b, predicted %b", want.motor_slot,
                           got.current_clipped, want.current_clipped));
        if (got.frame_payload !== want.frame_payload)
          report($sformatf("motor %0d frame_payload %h, predicted %h", want.motor_slot,
                           got.frame_payload, want.frame_payload));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  bit gaps_on;
  bit stall_on;
  bit long_hold_req;

  gain_plan_t phase_plan [8] = '{GAINS_SMALL, GAINS_WIDE, GAINS_MAX, GAINS_SMALL,
                                 GAINS_MIN, GAINS_SMALL, GAINS_OFF, GAINS_SMALL};

  current_cmd_scoreboard_t sb = new();

  motor_speed_pid_current_cmd_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Sample both streams at the rising edge
  always @(posedge clk) begin : monitor
    in_item_t fb;
    result_t  got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        fb = s_axis_tdata[$bits(in_item_t)-1:0];
        sb.note_feedback(fb);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.motor_slot      = m_axis_tdata[MOTOR_W-1:0];
        got.drive_current   = m_axis_tdata[MOTOR_W +: CUR_W];
        got.frame_payload   = m_axis_tdata[MOTOR_W+CUR_W +: FRAME_W];
        got.current_clipped = m_axis_tuser[0];
        sb.check_command(got);
      end
    end
  end

  // Result side: random stall bursts, plus a long hold on request
  initial begin : result_sink
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one feedback transaction and hold it until accepted
  task automatic send_feedback(int motor, int meas, int targ);
    in_item_t fb;
    int       n;
    fb.motor_number   = motor[MOTOR_W-1:0];
    fb.measured_speed = meas[SPEED_W-1:0];
    fb.target_speed   = targ[SPEED_W-1:0];
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(fb);
    do @(posedge clk); while (!s_axis_tready);
    // optional idle burst after the transaction
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic stop_feedback();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Program all six registers for one random phase
  task automatic apply_gains(gain_plan_t plan);
    logic [CFG_DATA_W-1:0] kp, ki, kd, dz, ist, imx;
    case (plan)
      GAINS_SMALL: begin
        kp  = CFG_DATA_W'($urandom_range(0, 4096) - 2048);
        ki  = CFG_DATA_W'($urandom_range(0, 512) - 256);
        kd  = CFG_DATA_W'($urandom_range(0, 2048) - 1024);
        dz  = CFG_DATA_W'($urandom_range(0, 40));
        ist = CFG_DATA_W'($urandom_range(0, 3000));
        imx = CFG_DATA_W'($urandom_range(0, 20000));
      end
      GAINS_WIDE: begin
        kp  = CFG_DATA_W'($urandom());
        ki  = CFG_DATA_W'($urandom());
        kd  = CFG_DATA_W'($urandom());
        dz  = CFG_DATA_W'($urandom_range(0, 65535));
        ist = CFG_DATA_W'($urandom_range(0, 131071));
        imx = CFG_DATA_W'($urandom_range(0, 1048575));
      end
      GAINS_MAX: begin
        kp  = 24'h800000;
        ki  = 24'h7fffff;
        kd  = 24'h7fffff;
        dz  = '0;
        ist = 24'd131071;
        imx = 24'd1048575;
      end
      GAINS_MIN: begin
        kp  = 24'h7fffff;
        ki  = 24'h800000;
        kd  = 24'h800000;
        dz  = 24'd65535;
        ist = '0;
        imx = '0;
      end
      default: begin
        kp  = '0;
        ki  = '0;
        kd  = '0;
        dz  = '0;
        ist = '0;
        imx = '0;
      end
    endcase
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_DZ, dz);
    write_reg(REG_ISTART, ist);
    write_reg(REG_IMAX, imx);
  endtask

  // Mostly valid motors with speeds near the set point, some wild values
  task automatic send_random_feedback();
    int motor, targ, meas, span;
    if ($urandom_range(0, 15) == 0)
      motor = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MOTORS + 1, 7);
    else
      motor = $urandom_range(1, MOTORS);
    targ = $urandom_range(0, 65535) - 32768;
    if ($urandom_range(0, 3) == 0) begin
      meas = $urandom_range(0, 65535) - 32768;
    end else begin
      case ($urandom_range(0, 2))
        0:       span = 8;
        1:       span = 300;
        default: span = 3000;
      endcase
      meas = targ - ($urandom_range(0, 2 * span) - span);
      if (meas > 32767)
        meas = 32767;
      else if (meas < -32768)
        meas = -32768;
    end
    send_feedback(motor, meas, targ);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains: zero error, full-scale errors, invalid motors, limit edge
    send_feedback(1, 0, 0);
    send_feedback(4, -32768, 32767);
    send_feedback(2, 32767, -32768);
    send_feedback(3, 100, 200);
    send_feedback(0, 5, 6);
    send_feedback(5, -7, 9);
    send_feedback(7, 32767, -32768);
    send_feedback(4, 0, 500);
    send_feedback(4, 0, 501);
    send_feedback(1, 0, -500);
    send_feedback(1, 0, -501);
    stop_feedback();
    wait_drain();

    // Dead zone and integral separation around their thresholds
    write_reg(REG_KP, 24'd256);
    write_reg(REG_KI, 24'd64);
    write_reg(REG_KD, -24'sd128);
    write_reg(REG_DZ, 24'd5);
    write_reg(REG_ISTART, 24'd1000);
    write_reg(REG_IMAX, 24'd3000);
    send_feedback(1, 0, 3);
    send_feedback(1, 0, 5);
    send_feedback(1, 0, -5);
    repeat (4) send_feedback(2, 0, 999);
    send_feedback(2, 0, 1000);
    send_feedback(2, 0, -999);
    repeat (4) send_feedback(3, 0, -999);
    stop_feedback();
    wait_drain();

    // Lowered clamp: integral kept until the next integration step
    write_reg(REG_IMAX, 24'd100);
    send_feedback(3, 0, 2000);
    send_feedback(3, 0, 10);
    stop_feedback();
    wait_drain();

    // Random phases, one gain setting each
    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      apply_gains(phase_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result hold while the sender keeps offering
        if (p == 3 && i == 60) begin
          long_hold_req = 1'b1;
          gaps_on = 1'b0;
        end
        if (p == 3 && i == 140)
          gaps_on = 1'b1;
        // pause the sender until every command is back
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          stop_feedback();
          wait_drain();
        end
        send_random_feedback();
      end
      stop_feedback();
      wait_drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
